@@ design/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and constants of the double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int VALUE_W       = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 256;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell of both chains
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of signed 32-bit values on a chain of cells
// ----------------------------------------------------------------------------
// Requests enter on the slave stream: the op code in tuser, the value in
// tdata. Every request gives exactly one response word on the master stream
// in the cycle after it is taken: the affected value (popped, peeked or echoed
// push; zero on error), the item count after the request and a status (ok,
// empty error, full error); failed requests and unused op codes leave the
// contents alone. One request is taken every cycle, as long as the response
// register is empty or being drained in the same cycle. The storage is two
// chains of DEPTH cells that all update in the same cycle: the front chain
// keeps the items in order from the front (cell 0 is the front item), the
// back chain keeps them in order from the back (cell 0 is the back item).
// A push at one end shifts that end's chain by one place and writes the
// value into the first free cell of the other chain; a pop shifts only its
// own chain. Both ends are therefore always read at a fixed cell. Storage
// costs 2 x DEPTH x 32 flip-flops; contents need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // request side
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [deq_pkg::VALUE_W-1:0]            s_axis_tdata,  // [31:0] value
  input  logic [deq_pkg::OP_W-1:0]               s_axis_tuser,  // [2:0] op
  // response side
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [31:0] result_value, then item_count, then zero fill
  output logic [((deq_pkg::VALUE_W+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  output logic [deq_pkg::STATUS_W-1:0]           m_axis_tuser   // [1:0] status
);
  import deq_pkg::*;

  localparam int COUNT_W = $clog2(DEPTH+1);
  localparam int OUT_W   = ((VALUE_W+COUNT_W+7)/8)*8;

  // handshake and request fields
  logic                      in_acc;
  op_e                       op;
  logic signed [VALUE_W-1:0] value;

  // cell chains
  cell_ctrl_t                cell_ctrl;
  logic [COUNT_W-1:0]        count;
  logic signed [VALUE_W-1:0] f_q    [DEPTH];
  logic signed [VALUE_W-1:0] b_q    [DEPTH];
  logic signed [VALUE_W-1:0] f_prev [DEPTH];
  logic signed [VALUE_W-1:0] f_next [DEPTH];
  logic signed [VALUE_W-1:0] b_prev [DEPTH];
  logic signed [VALUE_W-1:0] b_next [DEPTH];

  // response
  logic signed [VALUE_W-1:0] rsp_value;
  logic [COUNT_W-1:0]        rsp_count;
  status_e                   rsp_status;

  // output register
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [COUNT_W-1:0]        out_count_q;
  status_e                   out_status_q;

  // a new request may come in whenever the response word leaves or is absent
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign value         = s_axis_tdata;

  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .op_i         (op),
    .value_i      (value),
    .front_i      (f_q[0]),
    .back_i       (b_q[0]),
    .ctrl_o       (cell_ctrl),
    .count_o      (count),
    .rsp_value_o  (rsp_value),
    .rsp_count_o  (rsp_count),
    .rsp_status_o (rsp_status)
  );

  // the pushed value enters at cell 0; the far end of each chain refills
  // from itself, which only ever lands beyond the stored items
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    if (gi == 0) begin : g_first
      assign f_prev[gi] = value;
      assign b_prev[gi] = value;
    end else begin : g_inner_prev
      assign f_prev[gi] = f_q[gi-1];
      assign b_prev[gi] = b_q[gi-1];
    end
    if (gi == DEPTH-1) begin : g_last
      assign f_next[gi] = f_q[gi];
      assign b_next[gi] = b_q[gi];
    end else begin : g_inner_next
      assign f_next[gi] = f_q[gi+1];
      assign b_next[gi] = b_q[gi+1];
    end

    deq_cell #(
      .DEPTH (DEPTH),
      .IDX   (gi)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .count_i  (count),
      .value_i  (value),
      .f_prev_i (f_prev[gi]),
      .f_next_i (f_next[gi]),
      .b_prev_i (b_prev[gi]),
      .b_next_i (b_next[gi]),
      .f_q_o    (f_q[gi]),
      .b_q_o    (b_q[gi])
    );
  end

  // response word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_value_q  <= rsp_value;
      out_count_q  <= rsp_count;
      out_status_q <= rsp_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_count_q, out_value_q});
  assign m_axis_tuser  = out_status_q;

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("request taken without a response word");

  a_rsp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_count_q == count))
    else $error("response count differs from stored count");

  a_front_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && count != '0 && (op == OP_PEEK_FRONT || op == OP_POP_FRONT))
    |=> (out_value_q == $past(f_q[0])))
    else $error("front read not taken from the front cell");

endmodule

`default_nettype wire

@@ design/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// one position of the front-ordered and back-ordered storage chains
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int IDX   = 0
) (
  input  logic                                   clk_i,
  input  deq_pkg::cell_ctrl_t                    ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]             count_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]     value_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]     f_prev_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]     f_next_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]     b_prev_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]     b_next_i,
  output logic signed [deq_pkg::VALUE_W-1:0]     f_q_o,
  output logic signed [deq_pkg::VALUE_W-1:0]     b_q_o
);
  import deq_pkg::*;

  localparam int COUNT_W = $clog2(DEPTH+1);

  logic signed [VALUE_W-1:0] f_q, f_d;
  logic signed [VALUE_W-1:0] b_q, b_d;
  logic                      at_tail;

  // this cell is the first free place of both chains
  assign at_tail = (count_i == COUNT_W'(IDX));

  always_comb begin
    f_d = f_q;
    if (ctrl_i.push_front) begin
      f_d = f_prev_i;
    end else if (ctrl_i.push_back && at_tail) begin
      f_d = value_i;
    end else if (ctrl_i.pop_front) begin
      f_d = f_next_i;
    end
  end

  always_comb begin
    b_d = b_q;
    if (ctrl_i.push_back) begin
      b_d = b_prev_i;
    end else if (ctrl_i.push_front && at_tail) begin
      b_d = value_i;
    end else if (ctrl_i.pop_back) begin
      b_d = b_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d;
    b_q <= b_d;
  end

  assign f_q_o = f_q;
  assign b_q_o = b_q;

endmodule

`default_nettype wire

@@ design/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// request decode, item count and response of the double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  deq_pkg::op_e                           op_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]     value_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]     front_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]     back_i,
  output deq_pkg::cell_ctrl_t                    ctrl_o,
  output logic [$clog2(DEPTH+1)-1:0]             count_o,
  output logic signed [deq_pkg::VALUE_W-1:0]     rsp_value_o,
  output logic [$clog2(DEPTH+1)-1:0]             rsp_count_o,
  output deq_pkg::status_e                       rsp_status_o
);
  import deq_pkg::*;

  localparam int COUNT_W = $clog2(DEPTH+1);

  logic [COUNT_W-1:0] count_q, count_d;
  cell_ctrl_t         cmd;
  logic               empty, full;

  assign empty = (count_q == '0);
  assign full  = (count_q == COUNT_W'(DEPTH));

  always_comb begin
    cmd          = '0;
    count_d      = count_q;
    rsp_value_o  = '0;
    rsp_status_o = ST_OK;
    unique case (op_i) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          rsp_status_o = ST_FULL;
        end else begin
          cmd.push_front = (op_i == OP_PUSH_FRONT);
          cmd.push_back  = (op_i == OP_PUSH_BACK);
          count_d        = count_q + COUNT_W'(1);
          rsp_value_o    = value_i;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (empty) begin
          rsp_status_o = ST_EMPTY;
        end else begin
          rsp_value_o   = (op_i == OP_POP_FRONT || op_i == OP_PEEK_FRONT) ? front_i : back_i;
          cmd.pop_front = (op_i == OP_POP_FRONT);
          cmd.pop_back  = (op_i == OP_POP_BACK);
          if (op_i == OP_POP_FRONT || op_i == OP_POP_BACK) begin
            count_d = count_q - COUNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign ctrl_o      = accept_i ? cmd : '0;
  assign rsp_count_o = count_d;
  assign count_o     = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(DEPTH))
    else $error("item count above depth");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && full && (op_i == OP_PUSH_FRONT || op_i == OP_PUSH_BACK))
    |=> $stable(count_q))
    else $error("refused push changed the count");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !empty && (op_i == OP_POP_FRONT || op_i == OP_POP_BACK))
    |=> (count_q == $past(count_q) - COUNT_W'(1)))
    else $error("pop did not take one item");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |-> (ctrl_o == '0))
    else $error("chain command without a request");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bounded double-ended queue
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and responses come back on the master
// stream. A scoreboard model of the queue (circular store, front pointer,
// fill count) predicts one response per accepted request. A monitor compares
// every response, field by field, with the oldest prediction. Both sides
// insert random idle bursts. A long receiver hold-off backs the block up
// into its input. The final stretch runs with no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  localparam int DEPTH          = DEPTH_DEFAULT;
  localparam int COUNT_W        = $clog2(DEPTH + 1);
  localparam int TDATA_W        = ((VALUE_W + COUNT_W + 7) / 8) * 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  // op codes with no operation behind them
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } deq_resp_t;

  // dut connections; the inputs that the bench drives are known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [VALUE_W-1:0]  s_axis_tdata  = '0;  // [31:0] value
  logic [OP_W-1:0]     s_axis_tuser  = '0;  // [2:0] op
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;        // [31:0] result_value, [40:32] item_count
  logic [STATUS_W-1:0] m_axis_tuser;        // [1:0] status

  // scoreboard copy of the queue
  logic [VALUE_W-1:0]  model_slots [DEPTH];
  int unsigned         model_head  = 0;
  int unsigned         model_count = 0;
  deq_resp_t           pending_responses[$];

  // bench control
  bit                  idle_on      = 1'b1;
  bit                  hold_request = 1'b0;
  int                  mismatch_count = 0;
  int                  quiet_cycles   = 0;
  deq_resp_t           got_resp;
  deq_resp_t           want_resp;

  always #5 clk_i = ~clk_i;

  double_ended_queue #(.DEPTH(DEPTH)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // queue model: applies one request and returns the response it causes
  // --------------------------------------------------------------------------
  function automatic deq_resp_t apply_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
    deq_resp_t   r;
    int unsigned slot;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            // front moves back by one place, wrapping below slot zero
            model_head = (model_head == 0) ? DEPTH - 1 : model_head - 1;
            slot = model_head;
          end else begin
            slot = (model_head + model_count) % DEPTH;
          end
          model_slots[slot] = value;
          model_count++;
          r.value = value;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT || op == OP_PEEK_FRONT)
            slot = model_head;
          else
            slot = (model_head + model_count - 1) % DEPTH;
          r.value = model_slots[slot];
          if (op == OP_POP_FRONT) begin
            model_head = (model_head + 1) % DEPTH;
            model_count--;
          end else if (op == OP_POP_BACK) begin
            model_count--;
          end
        end
      end
      default: ;  // unused codes change nothing
    endcase
    r.count = model_count[COUNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // request driver: called at a falling edge, returns at the falling edge
  // after the word is taken, with tvalid still high
  // --------------------------------------------------------------------------
  task automatic send_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_responses.push_back(apply_request(op, value));
    @(negedge clk_i);
  endtask

  // mostly uniform, now and then one of the extremes
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // push share given in percent, rare unused codes, the rest pops and peeks
  function automatic logic [OP_W-1:0] pick_op(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      return (roll == 0) ? OP_UNUSED_7 : OP_UNUSED_6;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    case ($urandom_range(0, 3))
      0:       return OP_POP_FRONT;
      1:       return OP_POP_BACK;
      2:       return OP_PEEK_FRONT;
      default: return OP_PEEK_BACK;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // response monitor
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch (%s) at %0t: expected value %h count %0d status %0d",
               what, $realtime, want_resp.value, want_resp.count, want_resp.status);
      $display("  got value %h count %0d status %0d fill %h",
               got_resp.value, got_resp.count, got_resp.status,
               m_axis_tdata[TDATA_W-1:VALUE_W+COUNT_W]);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_resp.value  = m_axis_tdata[VALUE_W-1:0];
      got_resp.count  = m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W];
      got_resp.status = m_axis_tuser;
      if (pending_responses.size() == 0) begin
        want_resp = '0;
        note_mismatch("response without request");
      end else begin
        want_resp = pending_responses.pop_front();
        if (got_resp.value !== want_resp.value)
          note_mismatch("result_value");
        else if (got_resp.count !== want_resp.count)
          note_mismatch("item_count");
        else if (got_resp.status !== want_resp.status)
          note_mismatch("status");
        else if (m_axis_tdata[TDATA_W-1:VALUE_W+COUNT_W] !== '0)
          note_mismatch("zero fill");
      end
    end
  end

  // --------------------------------------------------------------------------
  // response sink: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  always begin
    @(negedge clk_i);
    if (hold_request) begin
      hold_request = 1'b0;
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles where neither stream moves a word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // pops and peeks on an empty queue
  task automatic test_empty_errors();
    send_request(OP_PEEK_FRONT, 32'h1234_5678);
    send_request(OP_PEEK_BACK,  32'hffff_ffff);
    send_request(OP_POP_FRONT,  32'h0000_0000);
    send_request(OP_POP_BACK,   32'h8000_0000);
  endtask

  // extreme values at both ends, head wrap below slot zero, fifo and lifo order
  task automatic test_end_ordering();
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_PUSH_BACK,  32'h7fff_ffff);
    send_request(OP_PUSH_FRONT, 32'h0000_0000);
    send_request(OP_PUSH_BACK,  32'hffff_ffff);
    send_request(OP_PEEK_FRONT, 32'h0);
    send_request(OP_PEEK_BACK,  32'h0);
    send_request(OP_POP_BACK,   32'h0);
    send_request(OP_POP_FRONT,  32'h0);
    send_request(OP_POP_BACK,   32'h0);
    send_request(OP_POP_FRONT,  32'h0);
    send_request(OP_POP_FRONT,  32'h0);
    send_request(OP_PUSH_BACK,  32'h0000_0001);
    send_request(OP_POP_FRONT,  32'h0);
    send_request(OP_PUSH_FRONT, 32'h0000_0002);
    send_request(OP_POP_FRONT,  32'h0);
  endtask

  // codes with no operation, empty and non-empty
  task automatic test_unused_ops();
    send_request(OP_UNUSED_6, 32'hdead_beef);
    send_request(OP_UNUSED_7, 32'hffff_ffff);
    send_request(OP_PUSH_BACK, 32'h5a5a_a5a5);
    send_request(OP_UNUSED_6, 32'h0000_0000);
    send_request(OP_UNUSED_7, 32'h7fff_ffff);
  endtask

  // push-heavy until full and refused, then pop-heavy until empty and refused
  task automatic test_fill_and_drain();
    while (model_count < DEPTH)
      send_request(pick_op(85), pick_value());
    repeat (6) send_request(pick_op(100), pick_value());
    while (model_count > 0)
      send_request(pick_op(5), pick_value());
    repeat (4) send_request(pick_op(0), pick_value());
  endtask

  // phases with changing push share
  task automatic test_random_mix();
    int push_pct;
    repeat (6) begin
      push_pct = $urandom_range(25, 75);
      repeat (50) send_request(pick_op(push_pct), pick_value());
    end
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (40) send_request(pick_op(60), pick_value());
  endtask

  // full-rate traffic on both sides
  task automatic test_no_idle();
    idle_on = 1'b0;
    repeat (150) send_request(pick_op(55), pick_value());
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_errors();
    test_end_ordering();
    test_unused_ops();
    test_fill_and_drain();
    test_random_mix();
    test_backpressure();
    test_no_idle();

    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ double_ended_queue.f @@
design/deq_pkg.sv
design/deq_cell.sv
design/deq_ctrl.sv
design/double_ended_queue.sv
verif/tb.sv
